### rtl/core/bpbi_pkg.sv
`timescale 1ns / 1ps
package bpbi_pkg;

  localparam int CoordW = 17;
  localparam logic [CoordW-1:0] CoordMax = 17'd65536;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_BUILD   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_BIN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_SEG_POINTS = 2'd0,
    CFG_T_STEP     = 2'd1,
    CFG_BIN_COUNT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEG_FIRST,
    S_SEG_EVAL,
    S_SEG_END,
    S_BLD_LO,
    S_BLD_UP,
    S_BLD_TAIL,
    S_READ,
    S_READ_WAIT,
    S_ACK,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic emit_first;
    logic eval_start;
    logic emit_end;
    logic bld_lo_init;
    logic bld_lo_step;
    logic bld_up_init;
    logic bld_up_step;
    logic bld_tail;
    logic read_issue;
    logic read_take;
    logic ack;
    logic restart;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eval_done;
    logic eval_last;
    logic bld_done;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] v);
    clamp_coord = (v > CoordMax) ? CoordMax : v;
  endfunction

endpackage

### rtl/core/bpbi_in_if.sv
`timescale 1ns / 1ps
interface bpbi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [16:0] start_x;
  logic [16:0] start_y;
  logic [16:0] ctrl_x;
  logic [16:0] ctrl_y;
  logic [16:0] end_x;
  logic [16:0] end_y;
  logic        include_first;
  logic [10:0] bin_index;

  modport source (output valid, cmd, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                  include_first, bin_index, input ready);
  modport sink (input valid, cmd, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                include_first, bin_index, output ready);
endinterface

### rtl/core/bpbi_out_if.sv
`timescale 1ns / 1ps
interface bpbi_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] point_x;
  logic [16:0] point_y;
  logic [9:0]  bin_lower;
  logic        bin_lower_valid;
  logic [10:0] bin_upper;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, point_x, point_y, bin_lower, bin_lower_valid, bin_upper,
                  status, last, input ready);
  modport sink (input valid, point_x, point_y, bin_lower, bin_lower_valid, bin_upper,
                status, last, output ready);
endinterface

### rtl/core/bpbi_ram.sv
`timescale 1ns / 1ps
module bpbi_ram #(
  parameter int Width = 17,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/bpbi_ctrl.sv
`timescale 1ns / 1ps
module bpbi_ctrl
  import bpbi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [1:0] in_cmd,
  input  logic     in_include_first,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic   go;

  assign go = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          case (cmd_t'(in_cmd))
            CMD_ADD:   state_nxt = in_include_first ? S_SEG_FIRST : S_SEG_EVAL;
            CMD_BUILD: state_nxt = S_BLD_LO;
            CMD_READ:  state_nxt = S_READ;
            default:   state_nxt = S_ACK;
          endcase
        end
      end
      S_SEG_FIRST: if (!stat.out_busy) state_nxt = S_SEG_EVAL;
      // With only two points per segment there are no interior points to wait for.
      S_SEG_EVAL:  if (stat.eval_last || stat.eval_done) state_nxt = S_SEG_END;
      S_SEG_END:   if (!stat.out_busy) state_nxt = S_IDLE;
      S_BLD_LO:    if (stat.bld_done) state_nxt = S_BLD_UP;
      S_BLD_UP:    if (stat.bld_done) state_nxt = S_BLD_TAIL;
      S_BLD_TAIL:  state_nxt = S_ACK;
      S_READ:      state_nxt = S_READ_WAIT;
      S_READ_WAIT: if (!stat.out_busy) state_nxt = S_OUT;
      S_ACK:       if (!stat.out_busy) state_nxt = S_IDLE;
      S_OUT:       if (!stat.out_busy) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    cmd = '0;
    cmd.load_item = go;
    case (state_r)
      S_IDLE: begin
        cmd.bld_lo_init = go && (cmd_t'(in_cmd) == CMD_BUILD);
        cmd.eval_start  = go && (cmd_t'(in_cmd) == CMD_ADD) && !in_include_first;
        cmd.restart     = go && (cmd_t'(in_cmd) == CMD_RESTART);
      end
      S_SEG_FIRST: begin
        cmd.emit_first = !stat.out_busy;
        cmd.eval_start = !stat.out_busy;
      end
      S_SEG_END:   cmd.emit_end = !stat.out_busy;
      S_BLD_LO: begin
        cmd.bld_lo_step = 1'b1;
        cmd.bld_up_init = stat.bld_done;
      end
      S_BLD_UP:    cmd.bld_up_step = 1'b1;
      S_BLD_TAIL:  cmd.bld_tail = 1'b1;
      S_READ:      cmd.read_issue = 1'b1;
      S_READ_WAIT: cmd.read_take = !stat.out_busy;
      S_ACK:       cmd.ack = !stat.out_busy;
      default: ;
    endcase
  end
endmodule

### rtl/core/bpbi_dp.sv
`timescale 1ns / 1ps
module bpbi_dp
  import bpbi_pkg::*;
#(
  parameter int MaxPoints = 1024,
  parameter int MaxBins   = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  bpbi_in_if.sink     in_ch,
  bpbi_out_if.source  out_ch
);
  localparam int PW  = $clog2(MaxPoints);
  localparam int CW  = PW + 1;
  localparam int BW  = $clog2(MaxBins + 2);
  localparam int TD  = MaxBins + 2;

  // configuration
  logic [6:0]  seg_pts_r;
  logic [15:0] t_step_r;
  logic [10:0] bin_cnt_r;
  logic [6:0]  sp_eff;
  logic [BW-1:0] b_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_pts_r <= 7'd64;
      t_step_r  <= 16'd1040;
      bin_cnt_r <= 11'd1000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SEG_POINTS: seg_pts_r <= cfg_wdata[6:0];
        CFG_T_STEP:     t_step_r  <= cfg_wdata;
        CFG_BIN_COUNT:  bin_cnt_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sp_eff = seg_pts_r;
    if (seg_pts_r < 7'd2) sp_eff = 7'd2;
    if (seg_pts_r > 7'd64) sp_eff = 7'd64;
    if (bin_cnt_r == 11'd0) b_eff = BW'(1);
    else if (32'(bin_cnt_r) > MaxBins) b_eff = BW'(MaxBins);
    else b_eff = BW'(bin_cnt_r);
  end

  // latched item
  logic [16:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [10:0] bin_idx_r;
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x1_r <= clamp_coord(in_ch.start_x);
      y1_r <= clamp_coord(in_ch.start_y);
      x2_r <= clamp_coord(in_ch.ctrl_x);
      y2_r <= clamp_coord(in_ch.ctrl_y);
      x3_r <= clamp_coord(in_ch.end_x);
      y3_r <= clamp_coord(in_ch.end_y);
      bin_idx_r <= in_ch.bin_index;
    end
  end

  // point count and stores
  logic [CW-1:0] count_r;
  logic          pt_we;
  logic [16:0]   pt_wx, pt_wy;
  logic [PW-1:0] pt_raddr;
  logic [16:0]   pt_rx, pt_ry;

  // output register
  logic        ov_r;
  logic [16:0] opx_r, opy_r;
  logic [9:0]  olo_r;
  logic        olov_r;
  logic [10:0] oup_r;
  logic [1:0]  ost_r;
  logic        olast_r;
  logic        out_busy;
  assign out_busy = ov_r && !out_ch.ready;

  // Bezier evaluation pipeline: stage 0 picks t, stage 1 forms r and products,
  // stage 2 weights by the control points, stage 3 sums and rounds.
  logic [6:0]  k_r;
  logic        ev_run_r;
  logic [22:0] t_r;
  logic        v1_r, v2_r, v3_r, l1_r, l2_r, l3_r;
  logic signed [23:0] rr_s;
  logic signed [47:0] r2_r, rt_r, t2_r;
  logic signed [66:0] ax_r, bx_r, cx_r, ay_r, by_r, cy_r;
  logic signed [68:0] sx, sy;
  logic [16:0] px_r, py_r;
  logic        ev_stall;
  logic        ev_last_k;

  assign ev_stall  = v3_r && out_busy;
  assign ev_last_k = (k_r + 7'd1 >= sp_eff - 7'd1);

  function automatic logic [16:0] round_sat(input logic signed [68:0] s);
    logic [68:0] u;
    if (s <= 0) return 17'd0;
    u = (69'(s) + (69'd1 << 31)) >> 32;
    return (u > 69'(CoordMax)) ? CoordMax : u[16:0];
  endfunction

  assign rr_s = 24'sd65536 - $signed({1'b0, t_r});
  assign sx = ax_r + bx_r + cx_r;
  assign sy = ay_r + by_r + cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_run_r <= 1'b0;
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (!ev_stall) begin
      if (cmd.eval_start) begin
        ev_run_r <= (sp_eff > 7'd2);
        k_r      <= 7'd1;
        t_r      <= 23'(t_step_r);
      end else if (ev_run_r) begin
        ev_run_r <= !ev_last_k;
        k_r      <= k_r + 7'd1;
        t_r      <= t_r + 23'(t_step_r);
      end
      v1_r <= ev_run_r;
      l1_r <= ev_last_k;
      r2_r <= 48'(rr_s * rr_s);
      rt_r <= 48'(2 * rr_s * $signed({1'b0, t_r}));
      t2_r <= 48'($signed({1'b0, t_r}) * $signed({1'b0, t_r}));
      v2_r <= v1_r;
      l2_r <= l1_r;
      ax_r <= 67'(r2_r * $signed({1'b0, x1_r}));
      bx_r <= 67'(rt_r * $signed({1'b0, x2_r}));
      cx_r <= 67'(t2_r * $signed({1'b0, x3_r}));
      ay_r <= 67'(r2_r * $signed({1'b0, y1_r}));
      by_r <= 67'(rt_r * $signed({1'b0, y2_r}));
      cy_r <= 67'(t2_r * $signed({1'b0, y3_r}));
      v3_r <= v2_r;
      l3_r <= l2_r;
      px_r <= round_sat(sx);
      py_r <= round_sat(sy);
    end
  end

  // Emission of points.
  logic        emit;
  logic [16:0] ex, ey;
  logic        elast;
  always_comb begin
    emit = 1'b0; ex = x3_r; ey = y3_r; elast = 1'b0;
    if (cmd.emit_first) begin
      emit = 1'b1; ex = x1_r; ey = y1_r;
    end else if (v3_r && !out_busy) begin
      emit = 1'b1; ex = px_r; ey = py_r;
    end else if (cmd.emit_end) begin
      emit = 1'b1; elast = 1'b1;
    end
  end

  assign stat.eval_done = !ev_run_r && !v1_r && !v2_r && !v3_r;
  assign stat.eval_last = v3_r && l3_r && !out_busy;
  assign stat.out_busy  = out_busy;

  // Index build: walk bins, advancing the point iterator one step after each fresh store read.
  logic [BW-1:0] bi_r;
  logic [CW-1:0] it_r;
  logic          bup_r;
  logic          rd_ok_r;
  logic [47:0]   lhs;
  logic [47:0]   rhs;
  logic          adv;
  logic          tb_we;
  logic [BW-1:0] tb_waddr;
  logic [10:0]   tb_wdata;
  logic          lo_we, up_we;
  logic [BW-1:0] tb_raddr;
  logic [10:0]   lo_rd, up_rd;

  assign pt_raddr = it_r[PW-1:0];
  assign lhs = 48'(pt_rx) * 48'(b_eff);
  assign rhs = (48'(bi_r) + 48'(bup_r)) << 16;
  // rd_ok_r marks that the store read for it_r is valid this cycle.
  assign adv = rd_ok_r && (it_r < count_r) && (bup_r ? (lhs < rhs) : (lhs <= rhs));
  assign stat.bld_done = (cmd.bld_lo_step || cmd.bld_up_step) && !adv && rd_ok_r
                         && (bi_r == b_eff);

  always_ff @(posedge clk) begin
    if (cmd.bld_lo_init || cmd.bld_up_init) begin
      bi_r <= '0; it_r <= '0; bup_r <= cmd.bld_up_init; rd_ok_r <= 1'b0;
    end else if (cmd.bld_lo_step || cmd.bld_up_step) begin
      if (!rd_ok_r) begin
        rd_ok_r <= 1'b1;
      end else if (adv) begin
        it_r <= it_r + CW'(1);
        rd_ok_r <= 1'b0;
      end else begin
        bi_r <= bi_r + BW'(1);
      end
    end
  end

  always_comb begin
    tb_we = 1'b0; tb_waddr = bi_r; tb_wdata = 11'(it_r);
    if ((cmd.bld_lo_step || cmd.bld_up_step) && rd_ok_r && !adv) tb_we = 1'b1;
    if (cmd.bld_tail) begin
      tb_we = 1'b1; tb_waddr = b_eff + BW'(1); tb_wdata = 11'(count_r);
    end
  end
  assign lo_we = tb_we && (cmd.bld_lo_step || cmd.bld_tail);
  assign up_we = tb_we && (cmd.bld_up_step || cmd.bld_tail);
  assign tb_raddr = BW'(bin_idx_r);

  // Store writes: only point emissions write.
  assign pt_we = emit && (32'(count_r) < MaxPoints);
  assign pt_wx = ex;
  assign pt_wy = ey;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.restart) begin
      count_r <= '0;
    end else if (pt_we) begin
      count_r <= count_r + CW'(1);
    end
  end

  bpbi_ram #(.Width(17), .Depth(MaxPoints)) u_px (
    .clk(clk), .we(pt_we), .waddr(count_r[PW-1:0]), .wdata(pt_wx),
    .raddr(pt_raddr), .rdata(pt_rx));
  bpbi_ram #(.Width(17), .Depth(MaxPoints)) u_py (
    .clk(clk), .we(pt_we), .waddr(count_r[PW-1:0]), .wdata(pt_wy),
    .raddr(pt_raddr), .rdata(pt_ry));
  bpbi_ram #(.Width(11), .Depth(TD)) u_lo (
    .clk(clk), .we(lo_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(tb_raddr), .rdata(lo_rd));
  bpbi_ram #(.Width(11), .Depth(TD)) u_up (
    .clk(clk), .we(up_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(tb_raddr), .rdata(up_rd));

  logic bad_bin;
  assign bad_bin = 12'(bin_idx_r) > 12'(b_eff) + 12'd1;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (out_ch.ready) ov_r <= 1'b0;
      if (emit) begin
        ov_r <= 1'b1;
        opx_r <= ex; opy_r <= ey;
        olo_r <= '0; olov_r <= 1'b0; oup_r <= '0;
        ost_r <= pt_we ? ST_OK : ST_FULL;
        olast_r <= elast;
      end else if (cmd.ack) begin
        ov_r <= 1'b1;
        opx_r <= '0; opy_r <= '0; olo_r <= '0; olov_r <= 1'b0; oup_r <= '0;
        ost_r <= ST_OK; olast_r <= 1'b1;
      end else if (cmd.read_take) begin
        ov_r <= 1'b1;
        opx_r <= '0; opy_r <= '0; olast_r <= 1'b1;
        if (bad_bin) begin
          olo_r <= '0; olov_r <= 1'b0; oup_r <= '0; ost_r <= ST_BAD_BIN;
        end else begin
          olo_r <= (lo_rd != 11'd0) ? 10'(lo_rd - 11'd1) : 10'd0;
          olov_r <= (lo_rd != 11'd0);
          oup_r <= up_rd; ost_r <= ST_OK;
        end
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.point_x = opx_r;
  assign out_ch.point_y = opy_r;
  assign out_ch.bin_lower = olo_r;
  assign out_ch.bin_lower_valid = olov_r;
  assign out_ch.bin_upper = oup_r;
  assign out_ch.status = ost_r;
  assign out_ch.last = olast_r;

  logic unused_ok;
  assign unused_ok = ^{pt_ry, cmd.read_issue, cmd.emit_end, stat.eval_done};
endmodule

### rtl/core/bezier_polyline_bucket_index.sv
`timescale 1ns / 1ps
// Quadratic Bezier flattener with a uniform x bucket index. An add-segment item
// emits one point per cycle, unless the output stalls, from a four-stage
// evaluation pipeline. A build item walks the point store and the bins with one
// store read per step, paced by the single read port of the point store. One
// item is processed at a time.
module bezier_polyline_bucket_index
  import bpbi_pkg::*;
#(
  parameter int MaxPoints = 1024,
  parameter int MaxBins   = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  bpbi_in_if.sink     in_ch,
  bpbi_out_if.source  out_ch
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bpbi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_cmd(in_ch.cmd),
    .in_include_first(in_ch.include_first), .stat(stat),
    .in_ready(in_ch.ready), .cmd(cmd));

  bpbi_dp #(.MaxPoints(MaxPoints), .MaxBins(MaxBins)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .cmd(cmd), .stat(stat), .in_ch(in_ch), .out_ch(out_ch));
endmodule

### dv/bpbi_checker.sv
`timescale 1ns / 1ps
module bpbi_checker
  import bpbi_pkg::*;
#(
  parameter int MaxPoints = 1024,
  parameter int MaxBins   = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  bpbi_in_if          in_mon,
  bpbi_out_if         out_mon,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          full_seen
);

  typedef struct packed {
    logic [16:0] px;
    logic [16:0] py;
    logic [9:0]  lo;
    logic        lo_valid;
    logic [10:0] up;
    status_t     st;
    logic        last;
  } curve_result_t;

  curve_result_t expected_results[$];

  logic [16:0] store_x [MaxPoints];
  logic [16:0] store_y [MaxPoints];
  int          n_points;
  logic [10:0] lower_tab [MaxBins+2];
  logic [10:0] upper_tab [MaxBins+2];
  logic [6:0]  seg_pts;
  logic [15:0] t_inc;
  logic [10:0] bin_cnt;

  function automatic void queue_expected(input curve_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic logic [16:0] sat_coord(input logic [16:0] v);
    return (v > CoordMax) ? CoordMax : v;
  endfunction

  // Exact Q32 sum of the three weighted control points, rounded half up to Q16.
  function automatic logic [16:0] curve_at(input longint p0, input longint p1,
                                           input longint p2, input longint t);
    longint r, s, u;
    r = 65536 - t;
    s = r * r * p0 + 2 * r * t * p1 + t * t * p2;
    if (s <= 0) return '0;
    u = (s + 64'sd2147483648) >>> 32;
    return (u > 65536) ? CoordMax : u[16:0];
  endfunction

  function automatic int active_bins();
    if (bin_cnt == 0) return 1;
    return (bin_cnt > MaxBins) ? MaxBins : int'(bin_cnt);
  endfunction

  function automatic curve_result_t plain_result(input status_t st);
    curve_result_t r;
    r = '0;
    r.st = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic append_point(input logic [16:0] x, input logic [16:0] y,
                              input logic is_last);
    curve_result_t r;
    r = '0;
    r.px = x;
    r.py = y;
    r.last = is_last;
    if (n_points < MaxPoints) begin
      store_x[n_points] = x;
      store_y[n_points] = y;
      n_points++;
      r.st = ST_OK;
    end else begin
      r.st = ST_FULL;
    end
    queue_expected(r);
  endtask

  task automatic rebuild_index();
    int b, walk;
    b = active_bins();
    walk = 0;
    for (int i = 0; i <= b; i++) begin
      while (walk < n_points && longint'(store_x[walk]) * b <= longint'(i) * 65536)
        walk++;
      lower_tab[i] = 11'(walk);
    end
    walk = 0;
    for (int i = 0; i <= b; i++) begin
      while (walk < n_points && longint'(store_x[walk]) * b < longint'(i + 1) * 65536)
        walk++;
      upper_tab[i] = 11'(walk);
    end
    lower_tab[b+1] = 11'(n_points);
    upper_tab[b+1] = 11'(n_points);
  endtask

  task automatic predict_item();
    longint x1, y1, x2, y2, x3, y3, t;
    int sp, b;
    curve_result_t r;
    case (cmd_t'(in_mon.cmd))
      CMD_ADD: begin
        x1 = sat_coord(in_mon.start_x);
        y1 = sat_coord(in_mon.start_y);
        x2 = sat_coord(in_mon.ctrl_x);
        y2 = sat_coord(in_mon.ctrl_y);
        x3 = sat_coord(in_mon.end_x);
        y3 = sat_coord(in_mon.end_y);
        sp = (seg_pts < 2) ? 2 : (seg_pts > 64) ? 64 : int'(seg_pts);
        if (in_mon.include_first) append_point(x1[16:0], y1[16:0], 1'b0);
        for (int k = 1; k + 1 < sp; k++) begin
          t = longint'(k) * t_inc;
          append_point(curve_at(x1, x2, x3, t), curve_at(y1, y2, y3, t), 1'b0);
        end
        append_point(x3[16:0], y3[16:0], 1'b1);
      end
      CMD_BUILD: begin
        rebuild_index();
        queue_expected(plain_result(ST_OK));
      end
      CMD_READ: begin
        b = active_bins();
        if (in_mon.bin_index > b + 1) begin
          queue_expected(plain_result(ST_BAD_BIN));
        end else begin
          r = plain_result(ST_OK);
          // The lower table keeps index plus one so that zero means no point.
          if (lower_tab[in_mon.bin_index] != 0) begin
            r.lo = 10'(lower_tab[in_mon.bin_index] - 11'd1);
            r.lo_valid = 1'b1;
          end
          r.up = upper_tab[in_mon.bin_index];
          queue_expected(r);
        end
      end
      default: begin
        n_points = 0;
        queue_expected(plain_result(ST_OK));
      end
    endcase
  endtask

  task automatic check_result();
    curve_result_t got, want;
    got.px = out_mon.point_x;
    got.py = out_mon.point_y;
    got.lo = out_mon.bin_lower;
    got.lo_valid = out_mon.bin_lower_valid;
    got.up = out_mon.bin_upper;
    got.st = status_t'(out_mon.status);
    got.last = out_mon.last;
    results_seen++;
    if (got.st == ST_FULL) full_seen++;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t: unexpected result x=%0d y=%0d lo=%0d/%0b up=%0d st=%0d last=%0b",
                 $time, got.px, got.py, got.lo, got.lo_valid, got.up, got.st, got.last);
      return;
    end
    want = expected_results.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 40)
        $display({"%0t: mismatch expected x=%0d y=%0d lo=%0d/%0b up=%0d st=%0d last=%0b",
                  " actual x=%0d y=%0d lo=%0d/%0b up=%0d st=%0d last=%0b"}, $time,
                 want.px, want.py, want.lo, want.lo_valid, want.up, want.st, want.last,
                 got.px, got.py, got.lo, got.lo_valid, got.up, got.st, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      fail_count = 0;
      results_seen = 0;
      full_seen = 0;
      n_points = 0;
      seg_pts = 7'd64;
      t_inc = 16'd1040;
      bin_cnt = 11'd1000;
      for (int i = 0; i < MaxBins + 2; i++) begin
        lower_tab[i] = '0;
        upper_tab[i] = '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SEG_POINTS: seg_pts = cfg_wdata[6:0];
          CFG_T_STEP:     t_inc = cfg_wdata;
          CFG_BIN_COUNT:  bin_cnt = cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) predict_item();
    end
    pending <= expected_results.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import bpbi_pkg::*;

  localparam int MaxBins = 1024;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  bpbi_in_if  in_ch ();
  bpbi_out_if out_ch ();

  int fail_count, pending, results_seen, full_seen;
  int tx_idle_pct, rx_idle_pct;
  int hold_req, hold_seen, hold_left;
  int cur_bins, last_x, items_sent;
  bit bin_built [MaxBins+2];

  bezier_polyline_bucket_index dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  bpbi_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen),
    .full_seen   (full_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic send(input cmd_t c, input logic [16:0] sx, input logic [16:0] sy,
                      input logic [16:0] cx, input logic [16:0] cy,
                      input logic [16:0] ex, input logic [16:0] ey,
                      input logic inc, input logic [10:0] bi);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    in_ch.ctrl_x <= cx;
    in_ch.ctrl_y <= cy;
    in_ch.end_x <= ex;
    in_ch.end_y <= ey;
    in_ch.include_first <= inc;
    in_ch.bin_index <= bi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (c == CMD_BUILD)
      for (int i = 0; i <= cur_bins + 1; i++) bin_built[i] = 1'b1;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_ctl(input cmd_t c, input logic [10:0] bi);
    send(c, 17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
         17'($urandom), 17'($urandom), 1'($urandom), bi);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input int sp, input int ts, input int bc);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SEG_POINTS;
    cfg_wdata <= 16'(sp);
    @(posedge clk);
    cfg_index <= CFG_T_STEP;
    cfg_wdata <= 16'(ts);
    @(posedge clk);
    cfg_index <= CFG_BIN_COUNT;
    cfg_wdata <= 16'(bc);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_bins = (bc[10:0] == 0) ? 1 : (bc[10:0] > MaxBins) ? MaxBins : int'(bc[10:0]);
  endtask

  // Mostly a chain of segments with rising x, so that builds see a sorted polyline.
  task automatic random_item();
    int pick, ex, cx, tries;
    logic [10:0] bi;
    pick = $urandom_range(99);
    if (pick < 68) begin
      if ($urandom_range(9) == 0) begin
        send(CMD_ADD, 17'($urandom_range(131071)), 17'($urandom_range(131071)),
             17'($urandom_range(131071)), 17'($urandom_range(131071)),
             17'($urandom_range(131071)), 17'($urandom_range(131071)),
             1'($urandom), 11'd0);
      end else begin
        ex = last_x + $urandom_range(0, 4096);
        if (ex > 65536) ex = 65536;
        cx = $urandom_range(last_x, ex);
        send(CMD_ADD, 17'(last_x), 17'($urandom_range(65536)), 17'(cx),
             17'($urandom_range(65536)), 17'(ex), 17'($urandom_range(65536)),
             ($urandom_range(4) == 0), 11'd0);
        last_x = ex;
      end
    end else if (pick < 77) begin
      send_ctl(CMD_BUILD, 11'd0);
    end else if (pick < 97) begin
      if (!bin_built[0] || $urandom_range(3) == 0) begin
        bi = 11'($urandom_range(cur_bins + 2, 2047));
      end else begin
        tries = 0;
        do begin
          bi = 11'($urandom_range(0, cur_bins + 1));
          tries++;
        end while (!bin_built[bi] && tries < 8);
        if (!bin_built[bi]) bi = 11'd0;
      end
      send_ctl(CMD_READ, bi);
    end else begin
      send_ctl(CMD_RESTART, 11'd0);
      last_x = $urandom_range(2048);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SEG_POINTS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ADD;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.ctrl_x = '0;
    in_ch.ctrl_y = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    in_ch.include_first = 1'b0;
    in_ch.bin_index = '0;
    hold_req = 0;
    tx_idle_pct = 10;
    rx_idle_pct = 55;
    cur_bins = 1000;
    last_x = 0;
    items_sent = 0;
    foreach (bin_built[i]) bin_built[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings.
    send_ctl(CMD_RESTART, 11'd0);
    send_ctl(CMD_READ, 11'd2047);
    send_ctl(CMD_READ, 11'd1002);
    send_ctl(CMD_BUILD, 11'd0);
    send_ctl(CMD_READ, 11'd0);
    send_ctl(CMD_READ, 11'd1001);
    send(CMD_ADD, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 1'b1, 11'd0);
    send(CMD_ADD, 17'd0, 17'd65536, 17'd32768, 17'd0, 17'd65536, 17'd65536, 1'b0, 11'd0);
    send(CMD_ADD, 17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071,
         17'd131071, 1'b1, 11'd0);
    send_ctl(CMD_BUILD, 11'd0);
    send_ctl(CMD_READ, 11'd0);
    send_ctl(CMD_READ, 11'd1000);
    send_ctl(CMD_READ, 11'd1001);
    send_ctl(CMD_READ, 11'd500);
    send_ctl(CMD_RESTART, 11'd0);
    send_ctl(CMD_READ, 11'd1001);
    send(CMD_ADD, 17'd60000, 17'd100, 17'd65536, 17'd70000, 17'd1000, 17'd50000, 1'b1,
         11'd0);
    send_ctl(CMD_BUILD, 11'd0);
    send_ctl(CMD_READ, 11'd999);

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: set_config(2, 65535, 1);
        2: set_config(127, 1, 2047);
        3: set_config(0, 32768, 0);
        4: set_config(40, 4096, 16);
        default: set_config($urandom_range(2, 64), $urandom_range(65535),
                            $urandom_range(1, 1024));
      endcase
      tx_idle_pct = (ph <= 2) ? 10 : (ph <= 4) ? 55 : 0;
      rx_idle_pct = (ph <= 2) ? 55 : (ph <= 4) ? 10 : 0;
      for (int n = 0; n < 28; n++) begin
        if (ph == 5 && n == 4) hold_req++;
        random_item();
      end
    end

    drain();
    $display("Sent %0d items over six register settings; %0d results checked,",
             items_sent, results_seen);
    $display("%0d of them from a full point store.", full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
